### rtl/ile_pkg.sv
// Shared types and codes for the indexed list engine.
package ile_pkg;

    localparam logic [2:0] OP_ADD_FRONT  = 3'd0;
    localparam logic [2:0] OP_ADD_REAR   = 3'd1;
    localparam logic [2:0] OP_REM_FRONT  = 3'd2;
    localparam logic [2:0] OP_REM_REAR   = 3'd3;
    localparam logic [2:0] OP_REM_AT     = 3'd4;
    localparam logic [2:0] OP_INS_BEFORE = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  position;
        logic [31:0] new_value;
    } t_req;

    typedef struct packed {
        logic [31:0] removed_value;
        logic [1:0]  status;
        logic [6:0]  length;
        logic        is_empty;
    } t_rsp;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

### rtl/ile_cell.sv
// One list cell: holds an element and shifts with its neighbors.
module ile_cell #(
    parameter int WIDTH = 32,
    parameter int IW    = 6,
    parameter int IDX   = 0
) (
    input  logic                  i_clk,
    input  ile_pkg::t_cell_cmd    i_cmd,
    input  logic [IW-1:0]         i_slot,
    input  logic [WIDTH-1:0]      i_new,
    input  logic [WIDTH-1:0]      i_left,
    input  logic [WIDTH-1:0]      i_right,
    output logic [WIDTH-1:0]      o_val,
    output logic [WIDTH-1:0]      o_tap
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [WIDTH-1:0] r_val;
    logic [WIDTH-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins) begin
            if (MY_IDX == i_slot) begin
                n_val = i_new;
            end else if (MY_IDX > i_slot) begin
                n_val = i_left;
            end
        end else if (i_cmd.rem) begin
            if (MY_IDX >= i_slot) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_tap = (MY_IDX == i_slot) ? r_val : '0;

endmodule

### rtl/indexed_list_engine.sv
// Top level of the indexed list engine: request decode, count and the cell row.
//
// A request is taken at any edge where start is high, all cells shift or load at
// that same edge, and the result appears on o_result with o_valid high in the
// cycle after. busy stays low, so a new request may follow every cycle; the
// receiver cannot stall and must take each result in the cycle it is shown.
// This works because the row of cells all move one place at once and the OR
// tree picks out the element being removed. Stored elements have no reset;
// only the count and the result strobe are cleared.
module indexed_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ile_pkg::t_req  i_req,
    output logic           o_valid,
    output ile_pkg::t_rsp  o_result
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;
    localparam int XW   = (ELEM_WIDTH > 32) ? ELEM_WIDTH : 32;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       n_cnt;
    logic                r_valid;
    ile_pkg::t_rsp       r_rsp;
    ile_pkg::t_rsp       n_rsp;

    ile_pkg::t_cell_cmd  cmd;
    logic [IW-1:0]       slot;
    logic [1:0]          status;
    logic                full;
    logic [CMPW-1:0]     pos_x;
    logic [CMPW-1:0]     cnt_x;
    logic [XW-1:0]       new_x;
    logic [XW-1:0]       rem_x;
    logic [ELEM_WIDTH-1:0] new_elem;
    logic [ELEM_WIDTH-1:0] tap_or;
    logic [ELEM_WIDTH-1:0] vals [CAPACITY];
    logic [ELEM_WIDTH-1:0] taps [CAPACITY];

    assign busy     = 1'b0;
    assign full     = (r_cnt == CAP_CNT);
    assign pos_x    = CMPW'(i_req.position);
    assign cnt_x    = CMPW'(r_cnt);
    assign new_x    = XW'(i_req.new_value);
    assign new_elem = new_x[ELEM_WIDTH-1:0];

    always_comb begin
        cmd    = '0;
        slot   = '0;
        status = ile_pkg::ST_OK;
        case (i_req.op)
            ile_pkg::OP_ADD_FRONT: begin
                if (full) status = ile_pkg::ST_FULL;
                else cmd.ins = 1'b1;
            end
            ile_pkg::OP_ADD_REAR: begin
                slot = IW'(r_cnt);
                if (full) status = ile_pkg::ST_FULL;
                else cmd.ins = 1'b1;
            end
            ile_pkg::OP_REM_FRONT: begin
                if (r_cnt == '0) status = ile_pkg::ST_UNDER;
                else cmd.rem = 1'b1;
            end
            ile_pkg::OP_REM_REAR: begin
                slot = IW'(r_cnt - CW'(1));
                if (r_cnt == '0) status = ile_pkg::ST_UNDER;
                else cmd.rem = 1'b1;
            end
            ile_pkg::OP_REM_AT: begin
                slot = IW'(pos_x - CMPW'(1));
                if (pos_x == '0 || pos_x > cnt_x) status = ile_pkg::ST_RANGE;
                else cmd.rem = 1'b1;
            end
            ile_pkg::OP_INS_BEFORE: begin
                slot = IW'(pos_x - CMPW'(1));
                if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                    status = ile_pkg::ST_RANGE;
                end else if (full) begin
                    status = ile_pkg::ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                end
            end
            default: begin
                status = ile_pkg::ST_RANGE;
            end
        endcase
        if (!start) cmd = '0;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ELEM_WIDTH-1:0] left_v;
            logic [ELEM_WIDTH-1:0] right_v;
            if (g == 0) begin : g_first
                assign left_v = '0;
            end else begin : g_mid
                assign left_v = vals[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_v = vals[g];
            end else begin : g_inner
                assign right_v = vals[g+1];
            end
            ile_cell #(
                .WIDTH (ELEM_WIDTH),
                .IW    (IW),
                .IDX   (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (cmd),
                .i_slot  (slot),
                .i_new   (new_elem),
                .i_left  (left_v),
                .i_right (right_v),
                .o_val   (vals[g]),
                .o_tap   (taps[g])
            );
        end
    endgenerate

    always_comb begin
        tap_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            tap_or = tap_or | taps[i];
        end
    end

    assign rem_x = cmd.rem ? XW'(tap_or) : '0;

    always_comb begin
        n_cnt = r_cnt;
        if (cmd.ins) n_cnt = r_cnt + CW'(1);
        else if (cmd.rem) n_cnt = r_cnt - CW'(1);
        n_rsp.removed_value = rem_x[31:0];
        n_rsp.status        = status;
        n_rsp.length        = 7'(n_cnt);
        n_rsp.is_empty      = (n_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
            if (start) r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) r_rsp <= n_rsp;
    end

    assign o_valid  = r_valid;
    assign o_result = r_rsp;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_valid)
        else $error("request without result strobe");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |=> !o_valid)
        else $error("result strobe without request");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ile_pkg::ST_FULL) |-> (r_cnt == CAP_CNT))
        else $error("full status with room left");

    a_under_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ile_pkg::ST_UNDER) |->
        (o_result.is_empty && r_cnt == '0))
        else $error("underflow status on a non-empty list");

endmodule

### bench/indexed_list_engine_checker.sv
// Checker for the indexed list engine: predicts each transaction's result and compares it.
`timescale 1ns / 1ps

module indexed_list_engine_checker #(
    parameter int CAP = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  ile_pkg::t_req i_req,
    input  logic          o_valid,
    input  ile_pkg::t_rsp o_result,
    output int            o_fail_cnt,
    output int            o_pending
);

    logic [31:0]   shadow_cells [CAP];
    int            shadow_len;
    ile_pkg::t_rsp list_rsp_q [$];

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
        shadow_len = 0;
    end

    function automatic void put_cell(int k, logic [31:0] v);
        for (int j = shadow_len; j > k; j--) begin
            shadow_cells[j] = shadow_cells[j - 1];
        end
        shadow_cells[k] = v;
        shadow_len++;
    endfunction

    function automatic logic [31:0] take_cell(int k);
        logic [31:0] v;
        v = shadow_cells[k];
        for (int j = k; j + 1 < shadow_len; j++) begin
            shadow_cells[j] = shadow_cells[j + 1];
        end
        shadow_len--;
        return v;
    endfunction

    function automatic ile_pkg::t_rsp predict_list_op(ile_pkg::t_req r);
        ile_pkg::t_rsp p;
        int            pos;
        p   = '0;
        pos = int'(r.position);
        p.status = ile_pkg::ST_OK;
        case (r.op)
            ile_pkg::OP_ADD_FRONT: begin
                if (shadow_len >= CAP) p.status = ile_pkg::ST_FULL;
                else put_cell(0, r.new_value);
            end
            ile_pkg::OP_ADD_REAR: begin
                if (shadow_len >= CAP) p.status = ile_pkg::ST_FULL;
                else put_cell(shadow_len, r.new_value);
            end
            ile_pkg::OP_REM_FRONT: begin
                if (shadow_len == 0) p.status = ile_pkg::ST_UNDER;
                else p.removed_value = take_cell(0);
            end
            ile_pkg::OP_REM_REAR: begin
                if (shadow_len == 0) p.status = ile_pkg::ST_UNDER;
                else p.removed_value = take_cell(shadow_len - 1);
            end
            ile_pkg::OP_REM_AT: begin
                if (pos < 1 || pos > shadow_len) p.status = ile_pkg::ST_RANGE;
                else p.removed_value = take_cell(pos - 1);
            end
            ile_pkg::OP_INS_BEFORE: begin
                if (pos < 1 || pos > shadow_len + 1) p.status = ile_pkg::ST_RANGE;
                else if (shadow_len >= CAP) p.status = ile_pkg::ST_FULL;
                else put_cell(pos - 1, r.new_value);
            end
            default: p.status = ile_pkg::ST_RANGE;
        endcase
        p.length   = shadow_len[6:0];
        p.is_empty = (shadow_len == 0);
        return p;
    endfunction

    always @(posedge i_clk) begin
        ile_pkg::t_rsp want;
        if (i_rst_n) begin
            if (start && !busy) begin
                list_rsp_q.push_back(predict_list_op(i_req));
            end
            if (o_valid) begin
                if (list_rsp_q.size() == 0) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= 10) begin
                        $display("unexpected result: removed %h status %0d length %0d empty %0d",
                                 o_result.removed_value, o_result.status,
                                 o_result.length, o_result.is_empty);
                    end
                end else begin
                    want = list_rsp_q.pop_front();
                    if (o_result.removed_value !== want.removed_value ||
                        o_result.status !== want.status ||
                        o_result.length !== want.length ||
                        o_result.is_empty !== want.is_empty) begin
                        o_fail_cnt++;
                        if (o_fail_cnt <= 10) begin
                            $display({"mismatch at %0t: removed %h/%h status %0d/%0d ",
                                      "length %0d/%0d empty %0d/%0d (expected/actual)"},
                                     $realtime, want.removed_value, o_result.removed_value,
                                     want.status, o_result.status,
                                     want.length, o_result.length,
                                     want.is_empty, o_result.is_empty);
                        end
                    end
                end
            end
        end
        o_pending = list_rsp_q.size();
    end

endmodule

### bench/indexed_list_engine_tb.sv
// Testbench top for the indexed list engine: drives request sequences and reports the verdict.
`timescale 1ns / 1ps

module indexed_list_engine_tb;

    localparam int         CAP        = 64;
    localparam int         RAND_ITEMS = 1000;
    localparam int         CALM_TAIL  = 150;
    localparam logic [2:0] OP_RSVD_6  = 3'd6;
    localparam logic [2:0] OP_RSVD_7  = 3'd7;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    ile_pkg::t_req i_req;
    logic          o_valid;
    ile_pkg::t_rsp o_result;
    int            fail_cnt;
    int            pending;
    int            list_len;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    indexed_list_engine #(
        .CAPACITY   (CAP),
        .ELEM_WIDTH (32)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    indexed_list_engine_checker #(
        .CAP (CAP)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    function automatic void track_len(ile_pkg::t_req r);
        int pos;
        pos = int'(r.position);
        case (r.op)
            ile_pkg::OP_ADD_FRONT, ile_pkg::OP_ADD_REAR: if (list_len < CAP) list_len++;
            ile_pkg::OP_REM_FRONT, ile_pkg::OP_REM_REAR: if (list_len > 0) list_len--;
            ile_pkg::OP_REM_AT: if (pos >= 1 && pos <= list_len) list_len--;
            ile_pkg::OP_INS_BEFORE: begin
                if (pos >= 1 && pos <= list_len + 1 && list_len < CAP) list_len++;
            end
            default: ;
        endcase
    endfunction

    task automatic send_txn(input logic [2:0] op, input logic [6:0] pos,
                            input logic [31:0] val);
        ile_pkg::t_req r;
        r.op        = op;
        r.position  = pos;
        r.new_value = val;
        i_req <= r;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        track_len(r);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [2:0] pick_op(int add_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return roll[0] ? OP_RSVD_6 : OP_RSVD_7;
        if (roll < 3 + add_pct) begin
            case ($urandom_range(0, 2))
                0:       return ile_pkg::OP_ADD_FRONT;
                1:       return ile_pkg::OP_ADD_REAR;
                default: return ile_pkg::OP_INS_BEFORE;
            endcase
        end
        case ($urandom_range(0, 2))
            0:       return ile_pkg::OP_REM_FRONT;
            1:       return ile_pkg::OP_REM_REAR;
            default: return ile_pkg::OP_REM_AT;
        endcase
    endfunction

    function automatic logic [6:0] pick_pos(logic [2:0] op);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return 7'($urandom_range(0, 127));
        if (roll < 12) return '0;
        if (op == ile_pkg::OP_INS_BEFORE) return 7'($urandom_range(1, list_len + 1));
        if (list_len == 0) return 7'($urandom_range(0, 3));
        return 7'($urandom_range(1, list_len));
    endfunction

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int         seg_left;
        int         seg_mode;
        int         add_pct;
        logic [2:0] op;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_req    = '0;
        list_len = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_txn(ile_pkg::OP_REM_FRONT, 7'd0, 32'h0);
        send_txn(ile_pkg::OP_REM_REAR, 7'd0, 32'h0);
        send_txn(ile_pkg::OP_REM_AT, 7'd1, 32'h0);
        send_txn(ile_pkg::OP_INS_BEFORE, 7'd2, 32'h1111_1111);
        send_txn(ile_pkg::OP_INS_BEFORE, 7'd0, 32'h2222_2222);
        send_txn(ile_pkg::OP_INS_BEFORE, 7'd1, 32'h1234_5678);
        send_txn(ile_pkg::OP_REM_FRONT, 7'd0, 32'h0);
        send_txn(ile_pkg::OP_ADD_FRONT, 7'd0, 32'hFFFF_FFFF);
        send_txn(ile_pkg::OP_ADD_REAR, 7'd0, 32'h0);
        send_txn(ile_pkg::OP_INS_BEFORE, 7'd3, 32'hA5A5_A5A5);
        send_txn(ile_pkg::OP_INS_BEFORE, 7'd2, 32'h5A5A_5A5A);
        send_txn(ile_pkg::OP_REM_AT, 7'd5, 32'h0);
        send_txn(ile_pkg::OP_REM_AT, 7'd0, 32'h0);
        send_txn(ile_pkg::OP_REM_AT, 7'd4, 32'h0);
        send_txn(ile_pkg::OP_REM_AT, 7'd2, 32'h0);
        send_txn(OP_RSVD_6, 7'd1, 32'hDEAD_BEEF);
        send_txn(OP_RSVD_7, 7'd1, 32'hDEAD_BEEF);
        send_txn(ile_pkg::OP_INS_BEFORE, 7'd127, 32'hFFFF_FFFF);
        send_txn(ile_pkg::OP_REM_REAR, 7'd0, 32'h0);
        send_txn(ile_pkg::OP_REM_AT, 7'd1, 32'h0);
        send_txn(ile_pkg::OP_ADD_REAR, 7'd0, 32'h8000_0001);
        send_txn(ile_pkg::OP_REM_AT, 7'd1, 32'h0);
        wait_drained();

        seg_left = 0;
        seg_mode = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 120);
                seg_mode = (seg_mode + 1) % 3;
            end
            seg_left--;
            add_pct = (seg_mode == 0) ? 80 : (seg_mode == 1) ? 52 : 25;
            op = pick_op(add_pct);
            send_txn(op, pick_pos(op), pick_val());
            if (n == RAND_ITEMS / 2) begin
                wait_drained();
            end else if (n < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 7) == 0) begin
                idle_for($urandom_range(1, 18));
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("indexed_list_engine regression: pass");
        end else begin
            $display("indexed_list_engine regression: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("indexed_list_engine regression: fail");
        $finish;
    end

endmodule
